>>> rtl/core/tmx_pkg.sv
// Shared types and constants of the tape machine IR executor.
// Used by the channel interfaces and all modules under rtl/core.
package tmx_pkg;

	localparam int unsigned OFS_W  = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned OPC_W  = 4;

	typedef enum logic [OPC_W-1:0] {
		OP_ADD = 4'd0,
		OP_MOV = 4'd1,
		OP_CPY = 4'd2,
		OP_MUL = 4'd3,
		OP_CLR = 4'd4,
		OP_IN  = 4'd5,
		OP_OUT = 4'd6,
		OP_JNZ = 4'd7,
		OP_JMP = 4'd8
	} op_t;

endpackage

>>> rtl/core/tmx_if.sv
// Valid/ready channels of the tape machine IR executor: instruction words in,
// result words out. Depends on tmx_pkg for field widths.
interface tmx_instr_if import tmx_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OPC_W-1:0]        operation;
	logic signed [OFS_W-1:0] operand_a;
	logic signed [OFS_W-1:0] operand_b;
	logic signed [BYTE_W-1:0] scale;
	logic [BYTE_W-1:0]       in_byte;

	modport source (output valid, operation, operand_a, operand_b, scale, in_byte,
		input ready);
	modport sink (input valid, operation, operand_a, operand_b, scale, in_byte,
		output ready);
endinterface

interface tmx_res_if import tmx_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_valid;
	logic              jump_taken;

	modport source (output valid, out_byte, out_valid, jump_taken, input ready);
	modport sink (input valid, out_byte, out_valid, jump_taken, output ready);
endinterface

>>> rtl/core/tmx_ofs_mod.sv
// Two-stage reduction of a signed 16-bit offset modulo TAPE_SIZE.
// Reciprocal multiply, then remainder and bias fix. Depends on tmx_pkg.
module tmx_ofs_mod import tmx_pkg::*; #(
	parameter int unsigned TAPE_SIZE = 32768
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [OFS_W-1:0]      ofs,
	output logic [$clog2(TAPE_SIZE)-1:0] rem
);

	localparam int unsigned AW    = $clog2(TAPE_SIZE);
	localparam int unsigned SHIFT = OFS_W + AW;
	localparam int unsigned MW    = OFS_W + 1;
	localparam int unsigned PW    = OFS_W + MW;
	localparam int unsigned RW    = ((AW > OFS_W) ? AW : OFS_W) + 1;
	localparam logic [63:0] MULT_L = ((64'd1 << SHIFT) + 64'(TAPE_SIZE) - 64'd1)
		/ 64'(TAPE_SIZE);
	localparam logic [MW-1:0] MULT = MULT_L[MW-1:0];
	// offset is biased by 2^15 to make it unsigned; this undoes it afterwards
	localparam logic [63:0] BIAS_L = (64'd1 << (OFS_W - 1)) % 64'(TAPE_SIZE);
	localparam logic [RW-1:0] BIAS = RW'(BIAS_L);
	localparam logic [RW-1:0] SIZE_R = RW'(TAPE_SIZE);

	logic [OFS_W-1:0] ux;
	logic [OFS_W-1:0] ux_s1;
	logic [PW-1:0]    prod_s1;
	logic [OFS_W-1:0] quo;
	logic [OFS_W-1:0] rem16;
	logic [RW-1:0]    rw;
	logic [RW-1:0]    adj;
	logic [AW-1:0]    rem_s2;

	assign ux = {~ofs[OFS_W-1], ofs[OFS_W-2:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1   <= ux;
			prod_s1 <= PW'(ux) * PW'(MULT);
		end
	end

	// quotient is exact for any 16-bit value with this multiplier and shift
	always_comb begin
		quo   = OFS_W'(prod_s1 >> SHIFT);
		rem16 = ux_s1 - OFS_W'(32'(quo) * TAPE_SIZE);
		rw    = RW'(rem16);
		if (rw >= BIAS) begin
			adj = rw - BIAS;
		end else begin
			adj = rw + SIZE_R - BIAS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2 <= adj[AW-1:0];
		end
	end

	assign rem = rem_s2;

endmodule

>>> rtl/core/tmx_tape.sv
// Tape memory: one write port, one registered read port, write-to-read
// forwarding and the clearing pass after reset. Depends on tmx_pkg.
module tmx_tape import tmx_pkg::*; #(
	parameter int unsigned TAPE_SIZE = 32768
) (
	input  logic                         clk,
	input  logic                         arst_n,
	output logic                         busy,
	input  logic                         re,
	input  logic [$clog2(TAPE_SIZE)-1:0] raddr,
	output logic [BYTE_W-1:0]            rdata,
	input  logic                         we,
	input  logic [$clog2(TAPE_SIZE)-1:0] waddr,
	input  logic [BYTE_W-1:0]            wdata
);

	localparam int unsigned AW = $clog2(TAPE_SIZE);
	localparam logic [AW-1:0] LAST = AW'(TAPE_SIZE - 1);

	logic [BYTE_W-1:0] mem [TAPE_SIZE];
	logic [BYTE_W-1:0] ram_q;
	logic [BYTE_W-1:0] fwd_q;
	logic              fwd_hit_q;
	logic              busy_q;
	logic [AW-1:0]     clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			ram_q <= mem[raddr];
		end
	end

	// same-cycle write to the address being read: the array returns old data
	always_ff @(posedge clk) begin
		if (re) begin
			fwd_hit_q <= we && !busy_q && (waddr == raddr);
			fwd_q     <= wdata;
		end
	end

	assign rdata = fwd_hit_q ? fwd_q : ram_q;
	assign busy  = busy_q;

	clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (clr_q == LAST) |=> !busy_q)
		else $error("clearing pass did not end at last cell");

	no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !we)
		else $error("unexpected access during clearing");

endmodule

>>> rtl/core/tape_machine_ir_executor.sv
// Tape machine IR executor, top level.
// Depends on tmx_pkg, tmx_if, tmx_ofs_mod and tmx_tape.
//
// instr (sink) takes one IR instruction word per handshake; result (source)
// returns exactly one result word per instruction, in order.
// Pipeline: s1 reciprocal multiply of both offsets, s2 offset remainder,
// s3 head add and tape read (head updated here for move), then execute
// and tape write-back into the output register.
// Each word passes s1, s2, s3 and the output register. Throughput: one word
// per cycle while the receiver does not stall. A cell written by one
// instruction and read by the next is forwarded around the tape memory, so
// there are no bubbles. After reset the tape is cleared one cell per cycle:
// instr.ready stays low until the tape is clear. Head resets to cell zero.
// When the receiver stalls, the output register holds and the whole pipeline
// freezes; instr.ready follows result.ready while a result is waiting.
module tape_machine_ir_executor import tmx_pkg::*; #(
	parameter int unsigned TAPE_SIZE = 32768
) (
	input  logic         clk,
	input  logic         arst_n,
	tmx_instr_if.sink    instr,
	tmx_res_if.source    result
);

	localparam int unsigned AW = $clog2(TAPE_SIZE);
	localparam logic [AW:0] SIZE_W = (AW+1)'(TAPE_SIZE);

	logic              adv;
	logic              busy;
	logic              acc;
	logic              v_s1, v_s2, v_s3;
	logic [OPC_W-1:0]  op_s1, op_s2, op_s3;
	logic [BYTE_W-1:0] scale_s1, scale_s2, scale_s3;
	logic [BYTE_W-1:0] inb_s1, inb_s2, inb_s3;
	logic [BYTE_W-1:0] amt_s1, amt_s2, amt_s3;
	logic [AW-1:0]     rem_a, rem_b;
	logic [AW-1:0]     head_q;
	logic [AW:0]       sum_a, sum_b;
	logic [AW-1:0]     addr_a, addr_b;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr_dec;
	logic              we_dec;
	logic [AW-1:0]     waddr_s3;
	logic              we_s3;
	logic [BYTE_W-1:0] rd;
	logic [BYTE_W-1:0] wdata;
	logic [2*BYTE_W-1:0] prod;
	logic              res_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_valid_q;
	logic              jump_q;

	assign adv         = !res_valid_q || result.ready;
	assign instr.ready = adv && !busy;
	assign acc         = instr.valid && instr.ready;

	tmx_ofs_mod #(.TAPE_SIZE(TAPE_SIZE)) u_ofs_a (
		.clk (clk),
		.en  (adv),
		.ofs (instr.operand_a),
		.rem (rem_a)
	);

	tmx_ofs_mod #(.TAPE_SIZE(TAPE_SIZE)) u_ofs_b (
		.clk (clk),
		.en  (adv),
		.ofs (instr.operand_b),
		.rem (rem_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= instr.operation;
			scale_s1 <= instr.scale;
			inb_s1   <= instr.in_byte;
			amt_s1   <= instr.operand_b[BYTE_W-1:0];
			op_s2    <= op_s1;
			scale_s2 <= scale_s1;
			inb_s2   <= inb_s1;
			amt_s2   <= amt_s1;
			op_s3    <= op_s2;
			scale_s3 <= scale_s2;
			inb_s3   <= inb_s2;
			amt_s3   <= amt_s2;
			waddr_s3 <= waddr_dec;
			we_s3    <= v_s2 && we_dec;
		end
	end

	// s2: head-relative addresses, wrapped into the tape
	always_comb begin
		sum_a  = (AW+1)'(head_q) + (AW+1)'(rem_a);
		sum_b  = (AW+1)'(head_q) + (AW+1)'(rem_b);
		addr_a = (sum_a >= SIZE_W) ? AW'(sum_a - SIZE_W) : sum_a[AW-1:0];
		addr_b = (sum_b >= SIZE_W) ? AW'(sum_b - SIZE_W) : sum_b[AW-1:0];
		raddr  = (op_s2 == OP_JNZ) ? head_q : addr_a;
		we_dec = op_s2 inside {OP_ADD, OP_CPY, OP_MUL, OP_CLR, OP_IN};
		waddr_dec = (op_s2 inside {OP_CPY, OP_MUL}) ? addr_b : addr_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (adv && v_s2 && (op_s2 == OP_MOV)) begin
			head_q <= addr_a;
		end
	end

	tmx_tape #(.TAPE_SIZE(TAPE_SIZE)) u_tape (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (busy),
		.re     (adv),
		.raddr  (raddr),
		.rdata  (rd),
		.we     (adv && we_s3),
		.waddr  (waddr_s3),
		.wdata  (wdata)
	);

	// s3: execute against the cell just read
	always_comb begin
		prod = (2*BYTE_W)'(rd) * (2*BYTE_W)'(scale_s3);
		unique case (op_s3)
			OP_ADD:  wdata = rd + amt_s3;
			OP_CPY:  wdata = rd;
			OP_MUL:  wdata = prod[BYTE_W-1:0];
			OP_IN:   wdata = inb_s3;
			default: wdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q  <= (op_s3 == OP_OUT) ? rd : '0;
			out_valid_q <= (op_s3 == OP_OUT);
			jump_q      <= (op_s3 == OP_JMP) || ((op_s3 == OP_JNZ) && (rd != '0));
		end
	end

	assign result.valid      = res_valid_q;
	assign result.out_byte   = out_byte_q;
	assign result.out_valid  = out_valid_q;
	assign result.jump_taken = jump_q;

	no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !instr.ready)
		else $error("instruction accepted during tape clearing");

	head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(AW+1)'(head_q) < SIZE_W)
		else $error("head outside tape");

	s3_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 |=> result.valid)
		else $error("executed instruction lost before output");

	out_and_jump_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.out_valid && result.jump_taken))
		else $error("output and jump flagged together");

endmodule

>>> tb/testbench.sv
// Self-checking bench for tape_machine_ir_executor: directed and random IR words
// against an in-bench tape/head predictor. Depends on tmx_pkg, tmx_if and the RTL.
module testbench;
	import tmx_pkg::*;

	localparam int unsigned TAPE_CELLS = 32768;
	localparam int unsigned N_WORDS    = 950;
	localparam int unsigned CALM_FROM  = 850;
	localparam int unsigned HOLD_AT    = 200;
	localparam int unsigned HOLD_LEN   = 60;
	localparam int unsigned MAX_REPORT = 10;
	localparam logic [OPC_W-1:0] OPC_SPARE_LO = OPC_W'(OP_JMP + 1);
	localparam logic [OPC_W-1:0] OPC_SPARE_HI = '1;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              out_valid;
		logic              jump_taken;
	} res_t;

	class tape_scoreboard;
		bit [BYTE_W-1:0] cells [TAPE_CELLS];
		int unsigned     head;
		res_t            expected_q[$];
		int unsigned     mismatches;

		function int unsigned cell_at(logic signed [OFS_W-1:0] ofs);
			int t;
			t = (int'(head) + int'(ofs)) % int'(TAPE_CELLS);
			if (t < 0)
				t += int'(TAPE_CELLS);
			return t;
		endfunction

		function void note_instr(logic [OPC_W-1:0] opc, logic signed [OFS_W-1:0] a,
			logic signed [OFS_W-1:0] b, logic [BYTE_W-1:0] sc, logic [BYTE_W-1:0] ib);
			res_t r;
			r = '0;
			case (opc)
				OP_ADD: cells[cell_at(a)] += b[BYTE_W-1:0];
				OP_MOV: head = cell_at(a);
				OP_CPY: cells[cell_at(b)] = cells[cell_at(a)];
				// stored, not accumulated; low byte of the product
				OP_MUL: cells[cell_at(b)] = cells[cell_at(a)] * sc;
				OP_CLR: cells[cell_at(a)] = '0;
				OP_IN:  cells[cell_at(a)] = ib;
				OP_OUT: begin
					r.out_byte  = cells[cell_at(a)];
					r.out_valid = 1'b1;
				end
				OP_JNZ: r.jump_taken = (cells[head] != 0);
				OP_JMP: r.jump_taken = 1'b1;
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [BYTE_W-1:0] ob, logic ov, logic jt);
			res_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORT)
					$display("unexpected result word: out_byte %h out_valid %b jump_taken %b",
						ob, ov, jt);
				return;
			end
			want = expected_q.pop_front();
			if (ob !== want.out_byte || ov !== want.out_valid || jt !== want.jump_taken) begin
				mismatches++;
				if (mismatches <= MAX_REPORT)
					$display("result mismatch: out_byte %h/%h out_valid %b/%b jump_taken %b/%b (exp/got)",
						want.out_byte, ob, want.out_valid, ov, want.jump_taken, jt);
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	tmx_instr_if instr();
	tmx_res_if   result();

	tape_scoreboard sb = new();
	bit          calm;
	bit          held;
	int unsigned words_sent;
	int unsigned results_seen;

	tape_machine_ir_executor #(.TAPE_SIZE(TAPE_CELLS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result checked before the input word of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				sb.check_result(result.out_byte, result.out_valid, result.jump_taken);
				results_seen++;
			end
			if (instr.valid === 1'b1 && instr.ready === 1'b1)
				sb.note_instr(instr.operation, instr.operand_a, instr.operand_b,
					instr.scale, instr.in_byte);
		end
	end

	task automatic drive_word(logic [OPC_W-1:0] opc, logic signed [OFS_W-1:0] a,
		logic signed [OFS_W-1:0] b, logic [BYTE_W-1:0] sc, logic [BYTE_W-1:0] ib);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			instr.valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		instr.valid     = 1'b1;
		instr.operation = opc;
		instr.operand_a = a;
		instr.operand_b = b;
		instr.scale     = sc;
		instr.in_byte   = ib;
		do @(posedge clk); while (instr.ready !== 1'b1);
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		instr.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// mostly near the head so words touch each other's cells; sometimes anywhere
	function automatic logic signed [OFS_W-1:0] near_ofs(int unsigned span);
		int v;
		v = int'($urandom_range(0, 2 * span)) - int'(span);
		if ($urandom_range(0, 9) == 0)
			v = $urandom;
		return OFS_W'(v);
	endfunction

	task automatic random_word();
		logic [OPC_W-1:0]        opc;
		logic signed [OFS_W-1:0] a;
		logic signed [OFS_W-1:0] b;
		if ($urandom_range(0, 19) == 0)
			opc = OPC_W'($urandom_range(OPC_SPARE_LO, OPC_SPARE_HI));
		else
			opc = OPC_W'($urandom_range(OP_ADD, OP_JMP));
		a = near_ofs(opc == OP_MOV ? 2 : 6);
		b = (opc == OP_ADD) ? OFS_W'($urandom) : near_ofs(6);
		drive_word(opc, a, b, BYTE_W'($urandom), BYTE_W'($urandom));
	endtask

	// counted loop as a compiled program runs it: load count, body, decrement, test
	task automatic countdown_loop();
		int unsigned n;
		n = $urandom_range(1, 6);
		drive_word(OP_IN, '0, '0, '0, BYTE_W'(n));
		repeat (n) begin
			drive_word(OP_ADD, 16'sd1, OFS_W'($urandom), '0, '0);
			drive_word(OP_ADD, '0, -16'sd1, '0, '0);
			drive_word(OP_JNZ, '0, '0, '0, '0);
		end
	endtask

	initial begin
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm) begin
				result.ready = 1'b1;
				@(negedge clk);
			end else if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				result.ready = 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				result.ready = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end else begin
				result.ready = 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		instr.valid     = 1'b0;
		instr.operation = OP_ADD;
		instr.operand_a = '0;
		instr.operand_b = '0;
		instr.scale     = '0;
		instr.in_byte   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: cleared tape, wrap in both directions, extreme fields
		drive_word(OP_OUT, '0, '0, '0, '0);
		drive_word(OP_JNZ, '0, '0, '0, '0);
		drive_word(OP_JMP, '0, '0, '0, '0);
		drive_word(OP_ADD, '0, 16'sh7fff, '0, '0);
		drive_word(OP_JNZ, 16'sh7fff, '0, '0, '0);
		drive_word(OP_OUT, '0, '0, '0, '0);
		drive_word(OP_ADD, 16'sh8000, 16'sh8000, '0, '0);
		drive_word(OP_IN, -16'sd1, '0, '0, 8'ha5);
		drive_word(OP_OUT, 16'sh7fff, '0, '0, '0);
		drive_word(OP_MUL, -16'sd1, 16'sd1, 8'h80, '0);
		drive_word(OP_MUL, -16'sd1, 16'sd2, 8'h7f, '0);
		drive_word(OP_CPY, 16'sd1, 16'sh8000, '0, '0);
		drive_word(OP_OUT, '0, '0, '0, '0);
		drive_word(OP_MOV, -16'sd1, '0, '0, '0);
		drive_word(OP_OUT, '0, '0, '0, '0);
		drive_word(OP_JNZ, '0, '0, '0, '0);
		drive_word(OP_MOV, 16'sh7fff, '0, '0, '0);
		drive_word(OP_MOV, 16'sh8000, '0, '0, '0);
		drive_word(OP_CLR, 16'sd1, '0, '0, '0);
		drive_word(OP_OUT, 16'sd1, '0, '0, '0);
		drive_word(OP_IN, 16'sd2, '0, '0, 8'hff);
		drive_word(OPC_SPARE_LO, 16'sh7fff, 16'sh7fff, 8'hff, 8'hff);
		drive_word(OPC_SPARE_HI, 16'sh8000, 16'sh8000, 8'h80, 8'h00);
		drive_word(OP_MOV, 16'sd2, '0, '0, '0);
		drive_word(OP_OUT, '0, '0, '0, '0);
		drain();

		while (words_sent < N_WORDS) begin
			if (words_sent >= CALM_FROM)
				calm = 1'b1;
			if (words_sent >= N_WORDS / 2 && words_sent < N_WORDS / 2 + 8)
				drain();
			if ($urandom_range(0, 9) == 0)
				countdown_loop();
			else
				random_word();
		end
		@(negedge clk);
		instr.valid = 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule

>>> files.f
rtl/core/tmx_pkg.sv
rtl/core/tmx_if.sv
rtl/core/tmx_ofs_mod.sv
rtl/core/tmx_tape.sv
rtl/core/tape_machine_ir_executor.sv
tb/testbench.sv
